// ===== design/mcspg_pkg.sv =====
// ----------------------------------------------------------------------------
// Step pulse generator package
// Request codes, the line width and reset reload constants, and the per-channel command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcspg_pkg;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;

   localparam int          LINE_W            = 6;
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd20;

   typedef struct packed {
      logic        tick;
      logic        run;
      logic        stop;
      logic [31:0] raw_count;
      logic [15:0] half_period;
   } chan_cmd_type;

   typedef struct packed {
      logic        clk_line;
      logic        dir_line;
      logic        enable_line;
      logic        active;
      logic [15:0] position;
      logic [31:0] steps_left;
   } chan_status_type;

endpackage

`default_nettype wire

// ===== design/multi_channel_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// Multi-channel step pulse generator
// Step, direction and enable lines for a set of stepper channels.
//
// A request on req_ carries an opcode: tick advances every running channel,
// run loads a signed step count into the addressed channel and stop clears
// it. Every request returns one response on rsp_ with all line masks, the
// mask of running channels, and the position and remaining steps of the
// addressed channel after the request has been applied.
// csr_ writes the divider reload; it is always ready. The user must write it
// only while no request is in flight; the block itself does not enforce this.
// An accepted request sits in the request register until the response register
// is free; it is then applied and its response is registered there, which
// raises rsp_valid. One request is taken every cycle while req_stall is low; all
// channels update in parallel in a single pass between the request register and the
// response register.
// Reset clears all channel state, positions included, and loads a reload
// of 20. While rsp_stall holds a response, one more request is buffered in
// the request register and req_stall then rises until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_step_pulse_generator #(
   parameter int NUM_CHANNELS = 6
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire         [1:0]  req_opcode,
   input  wire         [2:0]  req_channel,
   input  wire  signed [31:0] req_step_count,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic        [5:0]  rsp_clk_lines,
   output logic        [5:0]  rsp_dir_lines,
   output logic        [5:0]  rsp_enable_lines,
   output logic        [5:0]  rsp_active_mask,
   output logic signed [15:0] rsp_position,
   output logic        [31:0] rsp_remaining_steps,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire         [15:0] csr_half_period_ticks
);

   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_opcode_ff;
   logic [2:0]         s1_channel_ff;
   logic signed [31:0] s1_step_count_ff;
   logic [15:0]        half_period_ff;
   logic               out_blocked;
   logic               fire;
   logic               chan_ok;
   logic [5:0]         clk_mask, dir_mask, en_mask, act_mask;
   logic [15:0]        sel_position;
   logic [31:0]        sel_steps;

   mcspg_pkg::chan_cmd_type    cmd    [NUM_CHANNELS];
   mcspg_pkg::chan_status_type status [NUM_CHANNELS];

   assign csr_ready   = 1'b1;
   assign out_blocked = rsp_valid && rsp_stall;
   assign req_stall   = s1_valid_ff && out_blocked;
   assign fire        = s1_valid_ff && !out_blocked;
   assign chan_ok     = 32'(s1_channel_ff) < NUM_CHANNELS;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         half_period_ff <= mcspg_pkg::HALF_PERIOD_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_valid && csr_ready) begin
            half_period_ff <= csr_half_period_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_opcode_ff     <= req_opcode;
         s1_channel_ff    <= req_channel;
         s1_step_count_ff <= req_step_count;
      end
   end

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
      assign cmd[i].tick        = fire && (s1_opcode_ff == mcspg_pkg::OP_TICK);
      assign cmd[i].run         = fire && (s1_opcode_ff == mcspg_pkg::OP_RUN)
                                  && (32'(s1_channel_ff) == 32'(i));
      assign cmd[i].stop        = fire && (s1_opcode_ff == mcspg_pkg::OP_STOP)
                                  && (32'(s1_channel_ff) == 32'(i));
      assign cmd[i].raw_count   = s1_step_count_ff;
      assign cmd[i].half_period = half_period_ff;

      mcspg_channel u_channel (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd[i]),
         .status_next (status[i])
      );
   end

   for (genvar k = 0; k < mcspg_pkg::LINE_W; k++) begin : g_mask
      if (k < NUM_CHANNELS) begin : g_used
         assign clk_mask[k] = status[k].clk_line;
         assign dir_mask[k] = status[k].dir_line;
         assign en_mask[k]  = status[k].enable_line;
         assign act_mask[k] = status[k].active;
      end else begin : g_unused
         assign clk_mask[k] = 1'b0;
         assign dir_mask[k] = 1'b0;
         assign en_mask[k]  = 1'b0;
         assign act_mask[k] = 1'b0;
      end
   end

   always_comb begin
      sel_position = 16'd0;
      sel_steps    = 32'd0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (32'(s1_channel_ff) == 32'(i)) begin
            sel_position = status[i].position;
            sel_steps    = status[i].steps_left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (fire) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_clk_lines       <= clk_mask;
         rsp_dir_lines       <= dir_mask;
         rsp_enable_lines    <= en_mask;
         rsp_active_mask     <= act_mask;
         rsp_position        <= sel_position;
         rsp_remaining_steps <= sel_steps;
      end
   end

   // Every running channel is also enabled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_active_mask & ~rsp_enable_lines) == 6'd0))
      else $error("active channel without enable");

   // A buffered request is kept while the response side is blocked.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_blocked) |=> s1_valid_ff)
      else $error("buffered request lost");

   // A stop on a real channel reports no steps left.
   assert property (@(posedge clock) disable iff (reset)
      (fire && chan_ok && s1_opcode_ff == mcspg_pkg::OP_STOP) |=>
         (rsp_remaining_steps == 32'd0))
      else $error("stop left steps behind");

   // A forward run reports its own count.
   assert property (@(posedge clock) disable iff (reset)
      (fire && chan_ok && s1_opcode_ff == mcspg_pkg::OP_RUN && s1_step_count_ff > 0) |=>
         (rsp_remaining_steps == $past(s1_step_count_ff)))
      else $error("run count not loaded");

   // A request for a channel that does not exist reports zeros.
   assert property (@(posedge clock) disable iff (reset)
      (fire && !chan_ok) |=> (rsp_position == 16'sd0 && rsp_remaining_steps == 32'd0))
      else $error("nonexistent channel reported state");

endmodule

`default_nettype wire

// ===== design/mcspg_channel.sv =====
// ----------------------------------------------------------------------------
// Step pulse generator channel
// Holds one channel's divider, clock, direction, enable, step count and
// position, and applies a tick, run or stop command when one is given.
// ----------------------------------------------------------------------------
`default_nettype none

module mcspg_channel (
   input  wire                        clock,
   input  wire                        reset,
   input  mcspg_pkg::chan_cmd_type    cmd,
   output mcspg_pkg::chan_status_type status_next
);

   logic        clk_ff, clk_in;
   logic        fwd_ff, fwd_in;
   logic        back_ff, back_in;
   logic        en_ff, en_in;
   logic [15:0] div_ff, div_in;
   logic [15:0] pos_ff, pos_in;
   logic [31:0] steps_ff, steps_in;
   logic        run_fwd;

   assign run_fwd = (cmd.raw_count != 32'd0) && !cmd.raw_count[31];

   always_comb begin
      clk_in   = clk_ff;
      fwd_in   = fwd_ff;
      back_in  = back_ff;
      en_in    = en_ff;
      div_in   = div_ff;
      pos_in   = pos_ff;
      steps_in = steps_ff;
      if (cmd.run) begin
         clk_in  = 1'b0;
         div_in  = 16'd0;
         en_in   = 1'b1;
         fwd_in  = run_fwd;
         back_in = !run_fwd;
         if (run_fwd) begin
            steps_in = cmd.raw_count;
         end else begin
            steps_in = 32'd0 - cmd.raw_count;
         end
      end else if (cmd.stop) begin
         clk_in   = 1'b0;
         fwd_in   = 1'b0;
         back_in  = 1'b0;
         en_in    = 1'b0;
         div_in   = 16'd0;
         steps_in = 32'd0;
      end else if (cmd.tick && en_ff && (steps_ff != 32'd0)) begin
         if (div_ff != 16'd0) begin
            div_in = div_ff - 16'd1;
         end else begin
            div_in = cmd.half_period;
            clk_in = !clk_ff;
            if (clk_ff) begin
               steps_in = steps_ff - 32'd1;
               if (fwd_ff) begin
                  pos_in = pos_ff + 16'd1;
               end else begin
                  pos_in = pos_ff - 16'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff   <= 1'b0;
         fwd_ff   <= 1'b0;
         back_ff  <= 1'b0;
         en_ff    <= 1'b0;
         div_ff   <= 16'd0;
         pos_ff   <= 16'd0;
         steps_ff <= 32'd0;
      end else begin
         clk_ff   <= clk_in;
         fwd_ff   <= fwd_in;
         back_ff  <= back_in;
         en_ff    <= en_in;
         div_ff   <= div_in;
         pos_ff   <= pos_in;
         steps_ff <= steps_in;
      end
   end

   assign status_next.clk_line    = clk_in;
   assign status_next.dir_line    = back_in;
   assign status_next.enable_line = en_in;
   assign status_next.active      = en_in && (steps_in != 32'd0);
   assign status_next.position    = pos_in;
   assign status_next.steps_left  = steps_in;

   // A stop always leaves the channel idle with nothing left to do.
   assert property (@(posedge clock) disable iff (reset)
      cmd.stop |=> (!en_ff && !clk_ff && steps_ff == 32'd0))
      else $error("channel not cleared after stop");

   // The divider never counts down while the channel has no steps left.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && !cmd.run && !cmd.stop && steps_ff == 32'd0) |=> $stable(div_ff))
      else $error("divider moved on an idle channel");

endmodule

`default_nettype wire

// ===== verif/step_pulse_checker.sv =====
// ----------------------------------------------------------------------------
// Step pulse generator checker
// Watches the request, response and register channels of the step pulse
// generator. It predicts the line masks, position and remaining steps for
// every accepted request and compares each response with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module step_pulse_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire  [1:0]  req_opcode,
   input  wire  [2:0]  req_channel,
   input  wire  [31:0] req_step_count,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire  [5:0]  rsp_clk_lines,
   input  wire  [5:0]  rsp_dir_lines,
   input  wire  [5:0]  rsp_enable_lines,
   input  wire  [5:0]  rsp_active_mask,
   input  wire  [15:0] rsp_position,
   input  wire  [31:0] rsp_remaining_steps,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire  [15:0] csr_half_period_ticks,
   output int          mismatches,
   output int          pending
);

   localparam int CHANNELS = mcspg_pkg::LINE_W;

   typedef struct packed {
      logic [5:0]  clk_lines;
      logic [5:0]  dir_lines;
      logic [5:0]  enable_lines;
      logic [5:0]  active_mask;
      logic [15:0] position;
      logic [31:0] remaining_steps;
   } line_status_type;

   logic [15:0]         half_period;
   logic [15:0]         position_of [CHANNELS];
   logic [31:0]         steps_left [CHANNELS];
   logic [15:0]         divider [CHANNELS];
   logic [CHANNELS-1:0] clock_level;
   logic [CHANNELS-1:0] forward;
   logic [CHANNELS-1:0] backward;
   logic [CHANNELS-1:0] enabled;
   line_status_type     expected_status_q [$];

   initial begin
      mismatches = 0;
      pending = 0;
   end

   function automatic void advance_channel(int c);
      if (!enabled[c] || steps_left[c] == 32'd0) begin
         return;
      end
      if (divider[c] != 16'd0) begin
         divider[c] = divider[c] - 16'd1;
         return;
      end
      divider[c] = half_period;
      if (!clock_level[c]) begin
         clock_level[c] = 1'b1;
      end else begin
         clock_level[c] = 1'b0;
         steps_left[c] = steps_left[c] - 32'd1;
         position_of[c] = forward[c] ? position_of[c] + 16'd1 : position_of[c] - 16'd1;
      end
   endfunction

   function automatic line_status_type apply_request(logic [1:0] op, logic [2:0] ch,
                                                     logic [31:0] raw);
      line_status_type status;
      logic            in_range;
      int              c;
      in_range = ch < CHANNELS;
      case (op)
         mcspg_pkg::OP_TICK: begin
            for (c = 0; c < CHANNELS; c++) begin
               advance_channel(c);
            end
         end
         mcspg_pkg::OP_RUN: begin
            if (in_range) begin
               clock_level[ch] = 1'b0;
               if (raw != 32'd0 && !raw[31]) begin
                  forward[ch] = 1'b1;
                  backward[ch] = 1'b0;
                  steps_left[ch] = raw;
               end else begin
                  forward[ch] = 1'b0;
                  backward[ch] = 1'b1;
                  steps_left[ch] = 32'd0 - raw;
               end
               divider[ch] = 16'd0;
               enabled[ch] = 1'b1;
            end
         end
         mcspg_pkg::OP_STOP: begin
            if (in_range) begin
               enabled[ch] = 1'b0;
               backward[ch] = 1'b0;
               divider[ch] = 16'd0;
               steps_left[ch] = 32'd0;
               clock_level[ch] = 1'b0;
               forward[ch] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      status.clk_lines = clock_level;
      status.dir_lines = backward;
      status.enable_lines = enabled;
      for (c = 0; c < CHANNELS; c++) begin
         status.active_mask[c] = enabled[c] && steps_left[c] != 32'd0;
      end
      if (in_range) begin
         status.position = position_of[ch];
         status.remaining_steps = steps_left[ch];
      end else begin
         status.position = 16'd0;
         status.remaining_steps = 32'd0;
      end
      return status;
   endfunction

   task automatic compare_field(string label, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         if (mismatches < 10) begin
            $display("Mismatch on %s: expected %h, got %h.", label, want, got);
         end
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      line_status_type want;
      int              c;
      if (reset) begin
         half_period = mcspg_pkg::HALF_PERIOD_RESET;
         for (c = 0; c < CHANNELS; c++) begin
            position_of[c] = 16'd0;
            steps_left[c] = 32'd0;
            divider[c] = 16'd0;
         end
         clock_level = '0;
         forward = '0;
         backward = '0;
         enabled = '0;
         expected_status_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status_q.size() == 0) begin
               if (mismatches < 10) begin
                  $display("Response with no request waiting for it.");
               end
               mismatches++;
            end else begin
               want = expected_status_q.pop_front();
               compare_field("clk_lines", 32'(rsp_clk_lines), 32'(want.clk_lines));
               compare_field("dir_lines", 32'(rsp_dir_lines), 32'(want.dir_lines));
               compare_field("enable_lines", 32'(rsp_enable_lines),
                             32'(want.enable_lines));
               compare_field("active_mask", 32'(rsp_active_mask), 32'(want.active_mask));
               compare_field("position", 32'(rsp_position), 32'(want.position));
               compare_field("remaining_steps", rsp_remaining_steps, want.remaining_steps);
            end
         end
         if (csr_valid && csr_ready) begin
            half_period = csr_half_period_ticks;
         end
         if (req_valid && !req_stall) begin
            expected_status_q.push_back(apply_request(req_opcode, req_channel,
                                                      req_step_count));
         end
      end
      pending <= expected_status_q.size();
   end

endmodule

`default_nettype wire

// ===== verif/multi_channel_step_pulse_generator_test.sv =====
// ----------------------------------------------------------------------------
// Step pulse generator testbench
// Drives directed and random tick, run, stop and unused-opcode requests through
// the step pulse generator under several divider reload settings, with random
// gaps and stalls on both channels and two long response hold-offs that fill
// the block. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_step_pulse_generator_test;

   localparam logic [1:0] OP_NOP = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic        [1:0]  req_opcode = mcspg_pkg::OP_TICK;
   logic        [2:0]  req_channel = 3'd0;
   logic signed [31:0] req_step_count = 32'sd0;
   logic               rsp_stall = 1'b0;
   logic               csr_valid = 1'b0;
   logic        [15:0] csr_half_period_ticks = mcspg_pkg::HALF_PERIOD_RESET;

   wire                req_stall;
   wire                rsp_valid;
   wire                csr_ready;
   wire         [5:0]  rsp_clk_lines;
   wire         [5:0]  rsp_dir_lines;
   wire         [5:0]  rsp_enable_lines;
   wire         [5:0]  rsp_active_mask;
   wire signed  [15:0] rsp_position;
   wire         [31:0] rsp_remaining_steps;

   int                 mismatches;
   int                 pending;
   int                 requests_sent = 0;
   bit                 sender_no_gaps = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   multi_channel_step_pulse_generator DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_channel        (req_channel),
      .req_step_count     (req_step_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_clk_lines      (rsp_clk_lines),
      .rsp_dir_lines      (rsp_dir_lines),
      .rsp_enable_lines   (rsp_enable_lines),
      .rsp_active_mask    (rsp_active_mask),
      .rsp_position       (rsp_position),
      .rsp_remaining_steps(rsp_remaining_steps),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_half_period_ticks(csr_half_period_ticks)
   );

   step_pulse_checker step_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_channel        (req_channel),
      .req_step_count     (req_step_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_clk_lines      (rsp_clk_lines),
      .rsp_dir_lines      (rsp_dir_lines),
      .rsp_enable_lines   (rsp_enable_lines),
      .rsp_active_mask    (rsp_active_mask),
      .rsp_position       (rsp_position),
      .rsp_remaining_steps(rsp_remaining_steps),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_half_period_ticks(csr_half_period_ticks),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   task automatic issue_request(logic [1:0] op, logic [2:0] ch, logic signed [31:0] count);
      int gap;
      gap = (sender_no_gaps || requests_sent % 60 >= 45) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_channel <= ch;
      req_step_count <= count;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic run_random_requests(int count);
      int                 pick;
      logic        [1:0]  op;
      logic        [2:0]  ch;
      logic signed [31:0] steps;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         op = pick < 62 ? mcspg_pkg::OP_TICK : pick < 80 ? mcspg_pkg::OP_RUN :
              pick < 94 ? mcspg_pkg::OP_STOP : OP_NOP;
         ch = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: steps = int'($urandom_range(0, 16)) - 8;
            5: steps = int'($urandom_range(0, 200)) - 100;
            6, 7: steps = $urandom;
            8: steps = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: steps = 32'sd0;
         endcase
         issue_request(op, ch, steps);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_half_period(logic [15:0] value);
      csr_valid <= 1'b1;
      csr_half_period_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int gap;
      int taken;
      taken = 0;
      @(posedge clock);
      forever begin
         if (taken == 250 || taken == 600) begin
            gap = 80;
         end else if (taken % 80 >= 60) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 9);
         end
         rsp_stall <= (gap > 0);
         if (gap > 0) begin
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      issue_request(OP_NOP, 3'd0, 32'sd0);
      issue_request(mcspg_pkg::OP_RUN, 3'd0, 32'sd3);
      issue_request(mcspg_pkg::OP_RUN, 3'd1, 32'sd0);
      issue_request(mcspg_pkg::OP_RUN, 3'd2, 32'h8000_0000);
      issue_request(mcspg_pkg::OP_RUN, 3'd3, 32'h7FFF_FFFF);
      issue_request(mcspg_pkg::OP_RUN, 3'd4, -32'sd1);
      issue_request(mcspg_pkg::OP_RUN, 3'd5, 32'sd1);
      issue_request(mcspg_pkg::OP_RUN, 3'd6, 32'sd5);
      issue_request(mcspg_pkg::OP_STOP, 3'd7, 32'sd0);
      issue_request(OP_NOP, 3'd7, -32'sd1);
      repeat (12) issue_request(mcspg_pkg::OP_TICK, 3'd0, 32'sd0);
      issue_request(mcspg_pkg::OP_STOP, 3'd3, 32'sd0);
      issue_request(OP_NOP, 3'd3, 32'sd0);
      run_random_requests(120);
      wait_until_drained();

      write_half_period(16'd0);
      run_random_requests(250);
      wait_until_drained();

      write_half_period(16'hFFFF);
      run_random_requests(40);
      wait_until_drained();

      write_half_period(16'($urandom_range(1, 3)));
      run_random_requests(250);
      wait_until_drained();

      write_half_period(16'($urandom_range(0, 7)));
      sender_no_gaps = 1'b1;
      run_random_requests(150);
      wait_until_drained();

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/mcspg_pkg.sv
design/mcspg_channel.sv
design/multi_channel_step_pulse_generator.sv
verif/step_pulse_checker.sv
verif/multi_channel_step_pulse_generator_test.sv
